FILE: sv/satl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// satl_pkg
// Shared types, constants and operation codes of the translation buffer.
// ----------------------------------------------------------------------------
package satl_pkg;

  localparam int unsigned SetCountDefault  = 32;
  localparam int unsigned WayCountDefault  = 4;
  localparam int unsigned PageShiftDefault = 13;

  localparam int unsigned VaWidth    = 64;
  localparam int unsigned PaWidth    = 44;
  localparam int unsigned AsnWidth   = 8;
  localparam int unsigned StampWidth = 64;
  localparam int unsigned CountWidth = 8;

  typedef enum logic [2:0] {
    OP_LOOKUP      = 3'd0,
    OP_PROBE       = 3'd1,
    OP_INSERT      = 3'd2,
    OP_INVAL_ADDR  = 3'd3,
    OP_INVAL_ASN   = 3'd4,
    OP_INVAL_INSTR = 3'd5,
    OP_INVAL_ALL   = 3'd6,
    OP_NONE        = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_WALK_READ,
    ST_WALK_WRITE,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic hit;
    logic evicted;
  } flags_t;

endpackage : satl_pkg
`default_nettype wire

FILE: sv/satl_set_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// satl_set_mem
// One row per set: all ways' entries and the set stamp counter, registered read.
// ----------------------------------------------------------------------------
module satl_set_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : satl_set_mem
`default_nettype wire

FILE: sv/set_assoc_tlb_lru.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru
// Set-associative translation buffer with space tags and stamp replacement.
// Lookup, probe, insert, address invalidate: the set row is read, then
// written back, then the result is offered. Space/flag invalidates and
// invalidate all read and write back every row in turn. One item at a time:
// a new one is accepted only after the last result is taken.
// After rst a clearing pass writes every row; no item is accepted
// until it ends.
// ----------------------------------------------------------------------------
module set_assoc_tlb_lru
  import satl_pkg::*;
#(
  parameter int unsigned SET_COUNT  = SetCountDefault,
  parameter int unsigned WAY_COUNT  = WayCountDefault,
  parameter int unsigned PAGE_SHIFT = PageShiftDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // kind[2:0], virtual_address[66:3], phys_address_in[110:67],
  // space_number[118:111], kernel_mode[119], instr_stream[120]
  input  wire logic [127:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // hit[0], translated_address[44:1], evicted[45], invalidated_count[53:46]
  output logic [55:0]      m_tdata
);

  localparam int unsigned SetBits = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int unsigned WayBits = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int unsigned VpnW    = VaWidth - PAGE_SHIFT;
  localparam int unsigned PpnW    = PaWidth - PAGE_SHIFT;
  localparam int unsigned EntW    = 1 + VpnW + PpnW + AsnWidth + 2 + StampWidth;
  localparam int unsigned RowW    = WAY_COUNT * EntW + StampWidth;
  localparam int unsigned Total   = SET_COUNT * WAY_COUNT;
  localparam logic [CountWidth-1:0] AllCount =
    (Total > 255) ? CountWidth'(255) : CountWidth'(Total);

  typedef struct packed {
    logic                  valid;
    logic [VpnW-1:0]       vpn;
    logic [PpnW-1:0]       ppn;
    logic [AsnWidth-1:0]   asn;
    logic                  kern;
    logic                  instr;
    logic [StampWidth-1:0] stamp;
  } entry_t;

  state_t state, state_next;
  op_t op;
  logic [VaWidth-1:0] va;
  logic [PpnW-1:0] ppn_in;
  logic [AsnWidth-1:0] asn_in;
  logic kern_in, instr_in;
  logic [SetBits-1:0] set_idx;
  logic [SetBits-1:0] walk;
  logic [CountWidth-1:0] count;
  flags_t flags;
  logic [PaWidth-1:0] xlat;

  logic mem_we;
  logic [SetBits-1:0] mem_waddr, mem_raddr;
  logic [RowW-1:0] mem_wdata, mem_rdata, mem_wsel;

  satl_set_mem #(.DEPTH(SET_COUNT), .WIDTH(RowW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wsel),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  entry_t rd_ent [WAY_COUNT];
  entry_t wr_ent [WAY_COUNT];
  logic [StampWidth-1:0] rd_ctr, wr_ctr, ctr_inc;
  logic [VpnW-1:0] vpn;
  logic [SetBits-1:0] in_set;

  assign vpn = va[VaWidth-1:PAGE_SHIFT];
  assign in_set = (SET_COUNT > 1) ? s_tdata[3+PAGE_SHIFT +: SetBits] : '0;
  assign ctr_inc = rd_ctr + StampWidth'(1);

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      rd_ent[w] = mem_rdata[w*EntW +: EntW];
    end
    rd_ctr = mem_rdata[WAY_COUNT*EntW +: StampWidth];
  end

  // match and victim selection
  logic lk_hit, pr_hit, any_inv;
  logic [WayBits-1:0] lk_way, ins_way, inv_way, min_way;
  logic [StampWidth-1:0] min_st;
  logic [CountWidth-1:0] inv_cnt;
  logic [WAY_COUNT-1:0] kill;

  always_comb begin
    lk_hit = 1'b0; pr_hit = 1'b0; any_inv = 1'b0;
    lk_way = '0; inv_way = '0; min_way = '0;
    min_st = rd_ent[0].stamp;
    inv_cnt = '0;
    kill = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (rd_ent[w].valid && rd_ent[w].vpn == vpn && rd_ent[w].asn == asn_in &&
          rd_ent[w].kern == kern_in && rd_ent[w].instr == instr_in) begin
        lk_hit = 1'b1;
        lk_way = WayBits'(w);
      end
      if (rd_ent[w].valid && rd_ent[w].vpn == vpn && rd_ent[w].asn == asn_in) begin
        pr_hit = 1'b1;
      end
      if (!rd_ent[w].valid) begin
        any_inv = 1'b1;
        inv_way = WayBits'(w);
      end
    end
    for (int w = 1; w < WAY_COUNT; w++) begin
      if (rd_ent[w].stamp < min_st) begin
        min_st = rd_ent[w].stamp;
        min_way = WayBits'(w);
      end
    end
    for (int w = 0; w < WAY_COUNT; w++) begin
      case (op)
        OP_INVAL_ADDR:  kill[w] = rd_ent[w].valid && rd_ent[w].vpn == vpn &&
                                  (asn_in == '0 || rd_ent[w].asn == asn_in);
        OP_INVAL_ASN:   kill[w] = rd_ent[w].valid && rd_ent[w].asn == asn_in;
        OP_INVAL_INSTR: kill[w] = rd_ent[w].valid && rd_ent[w].instr == instr_in;
        default:        kill[w] = 1'b0;
      endcase
      inv_cnt = inv_cnt + CountWidth'(kill[w]);
    end
    ins_way = any_inv ? inv_way : min_way;
  end

  // write-back row
  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      wr_ent[w] = rd_ent[w];
      if (state == ST_CLEAR) begin
        wr_ent[w] = '0;
      end else begin
        if (kill[w]) begin
          wr_ent[w].valid = 1'b0;
        end
        if (op == OP_LOOKUP && lk_hit && lk_way == WayBits'(w)) begin
          wr_ent[w].stamp = ctr_inc;
        end
        if (op == OP_INSERT && ins_way == WayBits'(w)) begin
          wr_ent[w] = '{valid: 1'b1, vpn: vpn, ppn: ppn_in, asn: asn_in,
                        kern: kern_in, instr: instr_in, stamp: ctr_inc};
        end
      end
    end
    wr_ctr = rd_ctr;
    if (state == ST_CLEAR) begin
      wr_ctr = '0;
    end else if ((op == OP_LOOKUP && lk_hit) || op == OP_INSERT) begin
      wr_ctr = ctr_inc;
    end
    for (int w = 0; w < WAY_COUNT; w++) begin
      mem_wdata[w*EntW +: EntW] = wr_ent[w];
    end
    mem_wdata[WAY_COUNT*EntW +: StampWidth] = wr_ctr;
  end

  // invalidate-all keeps the way stamps: clear only valid bits and counter
  logic [RowW-1:0] clr_row;
  always_comb begin
    clr_row = mem_rdata;
    for (int w = 0; w < WAY_COUNT; w++) begin
      clr_row[w*EntW + EntW - 1] = 1'b0;
    end
    clr_row[WAY_COUNT*EntW +: StampWidth] = '0;
  end

  assign mem_wsel = (state == ST_WALK_WRITE && op == OP_INVAL_ALL) ? clr_row : mem_wdata;

  logic init_done;
  logic walk_last;
  assign walk_last = (walk[SetBits-1:0] == SetBits'(SET_COUNT - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (s_tvalid && s_tready) begin
          case (op_t'(s_tdata[2:0]))
            OP_INVAL_ASN, OP_INVAL_INSTR: state_next = ST_WALK_READ;
            OP_INVAL_ALL:                 state_next = ST_WALK_READ;
            OP_NONE:                      state_next = ST_DONE;
            default:                      state_next = ST_READ;
          endcase
        end
      ST_READ:       state_next = ST_WRITE;
      ST_WRITE:      state_next = ST_DONE;
      ST_WALK_READ:  state_next = ST_WALK_WRITE;
      ST_WALK_WRITE: state_next = walk_last ? ST_DONE : ST_WALK_READ;
      ST_CLEAR:      state_next = walk_last ? ST_IDLE : ST_CLEAR;
      ST_DONE:       if (m_tready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready  = (state == ST_IDLE) && init_done;
    m_tvalid  = (state == ST_DONE);
    mem_we    = (state == ST_WRITE) || (state == ST_WALK_WRITE) || (state == ST_CLEAR);
    mem_waddr = (state == ST_WRITE) ? set_idx : walk[SetBits-1:0];
    mem_raddr = (state == ST_IDLE) ? in_set :
                (state == ST_WALK_WRITE) ? SetBits'(walk[SetBits-1:0] + SetBits'(1)) :
                (state == ST_READ) ? set_idx : walk[SetBits-1:0];
    m_tdata   = {2'b00, count, flags.evicted, xlat, flags.hit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      walk <= '0;
      init_done <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        walk <= walk_last ? '0 : walk + SetBits'(1);
        if (walk_last) init_done <= 1'b1;
      end else if (state == ST_WALK_WRITE) begin
        walk <= walk_last ? '0 : walk + SetBits'(1);
      end else if (state == ST_IDLE) begin
        walk <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid && s_tready) begin
      op       <= op_t'(s_tdata[2:0]);
      va       <= s_tdata[66:3];
      ppn_in   <= s_tdata[67+PAGE_SHIFT +: PpnW];
      asn_in   <= s_tdata[118:111];
      kern_in  <= s_tdata[119];
      instr_in <= s_tdata[120];
      set_idx  <= in_set;
      count    <= (op_t'(s_tdata[2:0]) == OP_INVAL_ALL) ? AllCount : '0;
      flags    <= '0;
      xlat     <= '0;
    end
    if (state == ST_READ) begin
      // nothing: read data arrives for ST_WRITE
    end
    if (state == ST_WRITE) begin
      count <= inv_cnt;
      flags.hit <= (op == OP_LOOKUP) ? lk_hit : (op == OP_PROBE) ? pr_hit : 1'b0;
      flags.evicted <= (op == OP_INSERT) && !any_inv;
      if (op == OP_LOOKUP && lk_hit) begin
        xlat <= {rd_ent[lk_way].ppn, va[PAGE_SHIFT-1:0]};
      end
    end
    if (state == ST_WALK_WRITE && op != OP_INVAL_ALL) begin
      count <= ((9'(count) + 9'(inv_cnt)) > 9'd255) ? 8'd255 : count + inv_cnt;
    end
  end

  assert property (@(posedge clk) disable iff (rst) s_tready |-> !m_tvalid)
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[45]) |-> !m_tdata[0])
    else $error("evicted with hit");

endmodule : set_assoc_tlb_lru
`default_nettype wire
